// File: hdl/i64dm_pkg.sv
// ----------------------------------------------------------------------------
// i64dm_pkg
// Shared types and constants for the 64-bit divide / modulo unit.
// ----------------------------------------------------------------------------
package i64dm_pkg;

  localparam logic [1:0] OP_DIV_U = 2'd0;
  localparam logic [1:0] OP_DIV_S = 2'd1;
  localparam logic [1:0] OP_REM_U = 2'd2;
  localparam logic [1:0] OP_REM_S = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIX  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;    // latch operands
    logic prep;    // take magnitudes, clear remainder
    logic step;    // one restoring iteration
    logic finish;  // sign fix-up, register result
  } dp_cmd_t;

  typedef struct packed {
    logic zero_den;
  } dp_status_t;

endpackage

// File: hdl/i64dm_ctrl.sv
// ----------------------------------------------------------------------------
// i64dm_ctrl
// Sequencer for the divide unit: load, prepare, iterate, fix up.
// ----------------------------------------------------------------------------
module i64dm_ctrl #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  i64dm_pkg::dp_status_t status,
  output i64dm_pkg::dp_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  i64dm_pkg::state_t state, state_next;
  logic [CW-1:0]     count, count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    unique case (state)
      i64dm_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = i64dm_pkg::S_PREP;
        end
      end
      i64dm_pkg::S_PREP: begin
        cmd.prep   = 1'b1;
        count_next = CW'(DATA_WIDTH - 1);
        state_next = status.zero_den ? i64dm_pkg::S_FIX : i64dm_pkg::S_DIV;
      end
      i64dm_pkg::S_DIV: begin
        cmd.step   = 1'b1;
        count_next = count - 1'b1;
        if (count == '0) begin
          state_next = i64dm_pkg::S_FIX;
        end
      end
      i64dm_pkg::S_FIX: begin
        cmd.finish = 1'b1;
        state_next = i64dm_pkg::S_IDLE;
      end
      default: begin
        state_next = i64dm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i64dm_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != i64dm_pkg::S_IDLE);

endmodule

// File: hdl/i64dm_datapath.sv
// ----------------------------------------------------------------------------
// i64dm_datapath
// Operand registers, restoring shift-subtract divider and sign fix-up.
// ----------------------------------------------------------------------------
module i64dm_datapath #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  i64dm_pkg::dp_cmd_t    cmd,
  output i64dm_pkg::dp_status_t status,
  input  logic [1:0]            req_type,
  input  logic [63:0]           dividend,
  input  logic [63:0]           divisor,
  output logic [63:0]           result_value,
  output logic                  zero_divisor
);

  localparam int W = DATA_WIDTH;

  logic [1:0]   op;
  logic [W-1:0] num;
  logic [W-1:0] den;
  logic [W-1:0] den_mag;
  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic         zero_den;
  logic         num_neg;
  logic         den_neg;

  logic         is_signed;
  logic         is_mod;
  logic         carry;
  logic [W-1:0] shifted;
  logic [W+1:0] diff;
  logic         take;
  logic [W-1:0] quo_fix;
  logic [W-1:0] rem_fix;

  always_comb begin
    is_signed = (op == i64dm_pkg::OP_DIV_S) || (op == i64dm_pkg::OP_REM_S);
    is_mod    = (op == i64dm_pkg::OP_REM_U) || (op == i64dm_pkg::OP_REM_S);
    carry     = rem[W-1];
    shifted   = {rem[W-2:0], quo[W-1]};
    diff      = {1'b0, carry, shifted} - {2'b00, den_mag};
    take      = carry || !diff[W+1];
    quo_fix   = (num_neg != den_neg) ? (W'(0) - quo) : quo;
    rem_fix   = num_neg ? (W'(0) - rem) : rem;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= req_type;
      num      <= dividend[W-1:0];
      den      <= divisor[W-1:0];
      zero_den <= (divisor[W-1:0] == '0);
    end
    if (cmd.prep) begin
      num_neg <= is_signed && num[W-1];
      den_neg <= is_signed && den[W-1];
      quo     <= (is_signed && num[W-1]) ? (W'(0) - num) : num;
      den_mag <= (is_signed && den[W-1]) ? (W'(0) - den) : den;
      rem     <= '0;
    end
    if (cmd.step) begin
      rem <= take ? diff[W-1:0] : shifted;
      quo <= {quo[W-2:0], take};
    end
    if (cmd.finish) begin
      zero_divisor <= zero_den;
      if (zero_den) begin
        result_value <= is_mod ? 64'(num) : 64'd0;
      end else begin
        result_value <= is_mod ? 64'(rem_fix) : 64'(quo_fix);
      end
    end
  end

  assign status.zero_den = zero_den;

endmodule

// File: hdl/int64_divide_modulo_unit.sv
// ----------------------------------------------------------------------------
// int64_divide_modulo_unit
// Unsigned / signed divide and modulo, one quotient bit per cycle.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------
//  request  | start, busy       | req_type, dividend, divisor
//  result   | done (one cycle)  | result_value, zero_divisor
//
//  A request passes from transfer to done through an operand prepare step,
//  DATA_WIDTH iterations of the shift-subtract loop and a fix-up step.
//  A zero divisor skips the loop.
//  busy is high from the transfer until done; a new start may be taken in
//  the cycle done is shown. The receiver cannot stall. rst is synchronous.
// ----------------------------------------------------------------------------
module int64_divide_modulo_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] result_value,
  output logic        zero_divisor
);

  i64dm_pkg::dp_cmd_t    cmd;
  i64dm_pkg::dp_status_t status;

  i64dm_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  i64dm_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .req_type    (req_type),
    .dividend    (dividend),
    .divisor     (divisor),
    .result_value(result_value),
    .zero_divisor(zero_divisor)
  );

  a_done_pulse : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_busy_after_start : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer did not raise busy");

  a_zero_div_quotient : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (divisor[DATA_WIDTH-1:0] == '0) &&
     ((req_type == i64dm_pkg::OP_DIV_U) || (req_type == i64dm_pkg::OP_DIV_S)))
    |=> ##2 (done && zero_divisor && (result_value == 64'd0)))
    else $error("zero divisor quotient wrong");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for int64_divide_modulo_unit. Requests cover all four
// operations, including divide by zero, the most negative value over minus
// one, and random operands of several magnitudes. Each request's result is
// predicted when the transfer happens and compared with the done-strobed
// output in order. Start is dropped at random (not while accepted_cnt is
// 400 to 599), and operand ports carry junk while it is so dropped.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          N_RANDOM = 900;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct {
    logic [63:0] value;
    logic        zero_den;
  } div_res_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [63:0] dividend;
  logic [63:0] divisor;
  logic        done;
  logic [63:0] result_value;
  logic        zero_divisor;

  div_req_t pending_q[$];
  div_res_t quotient_q[$];
  int       accepted_cnt;
  int       mismatch_cnt;

  int64_divide_modulo_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .dividend     (dividend),
    .divisor      (divisor),
    .done         (done),
    .result_value (result_value),
    .zero_divisor (zero_divisor)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic div_res_t predict_divmod(div_req_t r);
    logic        is_signed;
    logic        is_mod;
    logic        num_neg;
    logic        den_neg;
    logic [63:0] mag_num;
    logic [63:0] mag_den;
    logic [63:0] quo;
    div_res_t    res;
    is_signed = (r.op == i64dm_pkg::OP_DIV_S) || (r.op == i64dm_pkg::OP_REM_S);
    is_mod    = (r.op == i64dm_pkg::OP_REM_U) || (r.op == i64dm_pkg::OP_REM_S);
    num_neg   = is_signed && r.num[63];
    den_neg   = is_signed && r.den[63];
    mag_num   = num_neg ? -r.num : r.num;
    mag_den   = den_neg ? -r.den : r.den;
    if (r.den == 64'd0) begin
      res.value    = is_mod ? r.num : 64'd0;
      res.zero_den = 1'b1;
    end else begin
      quo = mag_num / mag_den;
      if (num_neg != den_neg) quo = -quo;
      res.value    = is_mod ? r.num - quo * r.den : quo;
      res.zero_den = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic add_req(input logic [1:0] op, input logic [63:0] num,
                         input logic [63:0] den);
    div_req_t r;
    r.op  = op;
    r.num = num;
    r.den = den;
    pending_q.push_back(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_corner();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return 64'd1;
      2: return ALL_ONES;
      3: return MOST_NEG;
      4: return MOST_POS;
      default: return 64'd2;
    endcase
  endfunction

  function automatic logic [63:0] rand_small(input int unsigned hi);
    logic [63:0] v;
    v = 64'($urandom_range(hi, 1));
    return $urandom_range(1) ? -v : v;
  endfunction

  // driver: offer the head request, drop start at random
  always @(negedge clk) begin
    if (rst || pending_q.size() == 0) begin
      start <= 1'b0;
    end else if (!(accepted_cnt >= 400 && accepted_cnt < 600) &&
                 $urandom_range(99) < 22) begin
      start    <= 1'b0;
      req_type <= 2'($urandom);
      dividend <= rand64();
      divisor  <= rand64();
    end else begin
      start    <= 1'b1;
      req_type <= pending_q[0].op;
      dividend <= pending_q[0].num;
      divisor  <= pending_q[0].den;
    end
  end

  always @(posedge clk) begin
    div_req_t r;
    if (!rst && start && !busy) begin
      r.op  = req_type;
      r.num = dividend;
      r.den = divisor;
      quotient_q.push_back(predict_divmod(r));
      void'(pending_q.pop_front());
      accepted_cnt++;
    end
  end

  // monitor
  always @(posedge clk) begin
    div_res_t want;
    if (!rst && done) begin
      if (quotient_q.size() == 0) begin
        report_mismatch("result with no request outstanding", result_value, 64'd0);
      end else begin
        want = quotient_q.pop_front();
        if (result_value !== want.value)
          report_mismatch("result_value", result_value, want.value);
        if (zero_divisor !== want.zero_den)
          report_mismatch("zero_divisor", 64'(zero_divisor), 64'(want.zero_den));
      end
    end
  end

  initial begin
    logic [1:0]  op;
    logic [63:0] num;
    logic [63:0] den;
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = i64dm_pkg::OP_DIV_U;
    dividend     = 64'd0;
    divisor      = 64'd0;
    accepted_cnt = 0;
    mismatch_cnt = 0;

    // directed: zero divisor, wrap case, sign combinations, extremes
    add_req(i64dm_pkg::OP_DIV_U, MOST_NEG, 64'd0);
    add_req(i64dm_pkg::OP_DIV_S, MOST_NEG, 64'd0);
    add_req(i64dm_pkg::OP_REM_U, ALL_ONES, 64'd0);
    add_req(i64dm_pkg::OP_REM_S, MOST_NEG, 64'd0);
    add_req(i64dm_pkg::OP_DIV_S, MOST_NEG, ALL_ONES);
    add_req(i64dm_pkg::OP_REM_S, MOST_NEG, ALL_ONES);
    add_req(i64dm_pkg::OP_DIV_U, MOST_NEG, ALL_ONES);
    add_req(i64dm_pkg::OP_REM_U, MOST_NEG, ALL_ONES);
    add_req(i64dm_pkg::OP_DIV_U, ALL_ONES, 64'd1);
    add_req(i64dm_pkg::OP_DIV_S, MOST_NEG, 64'd1);
    add_req(i64dm_pkg::OP_DIV_S, -64'd7, 64'd2);
    add_req(i64dm_pkg::OP_REM_S, -64'd7, 64'd2);
    add_req(i64dm_pkg::OP_DIV_S, 64'd7, -64'd2);
    add_req(i64dm_pkg::OP_REM_S, 64'd7, -64'd2);
    add_req(i64dm_pkg::OP_DIV_S, -64'd7, -64'd2);
    add_req(i64dm_pkg::OP_REM_S, -64'd7, -64'd2);
    add_req(i64dm_pkg::OP_REM_U, 64'd100, 64'd7);
    add_req(i64dm_pkg::OP_DIV_U, 64'd0, ALL_ONES);
    add_req(i64dm_pkg::OP_REM_U, ALL_ONES, ALL_ONES);
    add_req(i64dm_pkg::OP_DIV_U, 64'd5, 64'd9);
    add_req(i64dm_pkg::OP_REM_U, 64'd5, 64'd9);
    add_req(i64dm_pkg::OP_DIV_S, MOST_POS, MOST_NEG);
    add_req(i64dm_pkg::OP_REM_S, MOST_NEG, MOST_POS);
    add_req(i64dm_pkg::OP_DIV_U, ALL_ONES, MOST_NEG);

    for (int i = 0; i < N_RANDOM; i++) begin
      op = 2'($urandom);
      case ($urandom_range(9))
        4: begin
          num = rand64();
          den = rand_small(255);
        end
        5: begin
          num = rand_small(100000);
          den = rand_small(300);
        end
        6: begin
          num = $urandom_range(1) ? rand64() : pick_corner();
          den = 64'd0;
        end
        7: begin
          num = pick_corner();
          den = $urandom_range(1) ? pick_corner() : rand64();
        end
        8: begin
          num = 64'($urandom);
          den = rand64();
        end
        9: begin
          den = 64'($urandom_range(65535, 1));
          num = den * 64'($urandom);
          if ($urandom_range(1)) num = -num;
        end
        default: begin
          num = rand64();
          den = rand64() >> $urandom_range(63);
        end
      endcase
      add_req(op, num, den);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    while (quotient_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("int64_divide_modulo_unit: match");
    end else begin
      $display("int64_divide_modulo_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("int64_divide_modulo_unit: mismatch");
    $finish;
  end

endmodule

// File: int64_divide_modulo_unit.f
hdl/i64dm_pkg.sv
hdl/i64dm_ctrl.sv
hdl/i64dm_datapath.sv
hdl/int64_divide_modulo_unit.sv
test/testbench.sv
